/* rtl/cpf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_pkg
// types, constants and the mod-11 check helper shared by the taxpayer number
// check digit validator
// ----------------------------------------------------------------------------
package cpf_pkg;

    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned NUM_DIGITS_I = 11;
    localparam int unsigned BCD_W     = DIGIT_W * NUM_DIGITS_I;

    localparam logic [3:0] NUM_DIGITS = 4'd11;
    localparam logic [3:0] PLAIN_LEN  = 4'd11;
    localparam logic [3:0] PUNCT_LEN  = 4'd14;
    localparam logic [3:0] COUNT_MAX  = 4'd15;
    localparam logic [3:0] DOT_POS_A  = 4'd3;
    localparam logic [3:0] DOT_POS_B  = 4'd7;
    localparam logic [3:0] DASH_POS   = 4'd11;
    localparam logic [3:0] SUM1_TERMS = 4'd9;
    localparam logic [3:0] SUM2_TERMS = 4'd10;
    localparam logic [3:0] W1_TOP     = 4'd10;
    localparam logic [3:0] W2_TOP     = 4'd11;
    localparam logic [3:0] TENTH_IDX  = 4'd9;
    localparam logic [3:0] ELEVEN_IDX = 4'd10;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEN   = 3'd1;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
    localparam logic [2:0] ST_ALL_EQUAL = 3'd3;
    localparam logic [2:0] ST_CHECK_ONE = 3'd4;
    localparam logic [2:0] ST_CHECK_TWO = 3'd5;

    // reciprocal of 11 scaled by 2^14, exact quotient for sums below 1024
    localparam logic [10:0] MOD_RECIP = 11'd1490;
    localparam logic [3:0]  ELEVEN    = 4'd11;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_cpf_in;

    typedef struct packed {
        logic             is_valid;
        logic [2:0]       status;
        logic [BCD_W-1:0] digits_bcd;
    } t_cpf_out;

    typedef struct packed {
        logic [3:0]       char_count;
        logic             plain_ok;
        logic             punct_ok;
        logic             all_same;
        logic [8:0]       sum_one;
        logic [9:0]       sum_two;
        logic [3:0]       tenth;
        logic [3:0]       eleventh;
        logic [BCD_W-1:0] digits;
    } t_cpf_tally;

    function automatic logic [3:0] check_from_sum(input logic [9:0] sum);
        logic [20:0] prod;
        logic [6:0]  quot;
        logic [9:0]  rem;
        prod = 21'(sum) * 21'(MOD_RECIP);
        quot = prod[20:14];
        rem  = sum - 10'(quot * 7'(ELEVEN));
        check_from_sum = (rem < 10'd2) ? 4'd0 : 4'(10'(ELEVEN) - rem);
    endfunction

endpackage
`default_nettype wire

/* rtl/cpf_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_acc
// running state: form checks by position, digit capture and the two
// weighted sums; gives the updated tally for the character in hand
// ----------------------------------------------------------------------------
module cpf_acc (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire cpf_pkg::t_cpf_in    i_item,
    output cpf_pkg::t_cpf_tally      o_tally
);
    import cpf_pkg::*;

    logic [3:0]       r_char_count, n_char_count;
    logic [3:0]       r_digit_count, n_digit_count;
    logic             r_plain_ok, n_plain_ok;
    logic             r_punct_ok, n_punct_ok;
    logic [3:0]       r_first, n_first;
    logic             r_all_same, n_all_same;
    logic [8:0]       r_sum_one, n_sum_one;
    logic [9:0]       r_sum_two, n_sum_two;
    logic [3:0]       r_tenth, n_tenth;
    logic [3:0]       r_eleventh, n_eleventh;
    logic [BCD_W-1:0] r_digits, n_digits;

    logic       is_digit;
    logic       take;
    logic       punct_char_ok;
    logic [3:0] digit;
    logic [3:0] w_one;
    logic [3:0] w_two;

    always_comb begin
        is_digit = (i_item.character >= CHAR_ZERO) && (i_item.character <= CHAR_NINE);
        digit    = i_item.character[3:0];
        take     = is_digit && (r_digit_count < NUM_DIGITS);
        w_one    = W1_TOP - r_digit_count;
        w_two    = W2_TOP - r_digit_count;

        if (r_char_count >= PUNCT_LEN) begin
            punct_char_ok = 1'b0;
        end else if ((r_char_count == DOT_POS_A) || (r_char_count == DOT_POS_B)) begin
            punct_char_ok = (i_item.character == CHAR_DOT);
        end else if (r_char_count == DASH_POS) begin
            punct_char_ok = (i_item.character == CHAR_DASH);
        end else begin
            punct_char_ok = is_digit;
        end

        n_plain_ok   = r_plain_ok && (r_char_count < PLAIN_LEN) && is_digit;
        n_punct_ok   = r_punct_ok && punct_char_ok;
        n_char_count = (r_char_count < COUNT_MAX) ? r_char_count + 4'd1 : r_char_count;

        n_first       = r_first;
        n_all_same    = r_all_same;
        n_sum_one     = r_sum_one;
        n_sum_two     = r_sum_two;
        n_tenth       = r_tenth;
        n_eleventh    = r_eleventh;
        n_digits      = r_digits;
        n_digit_count = r_digit_count;
        if (take) begin
            if (r_digit_count == 4'd0) begin
                n_first = digit;
            end else if (digit != r_first) begin
                n_all_same = 1'b0;
            end
            if (r_digit_count < SUM1_TERMS) begin
                n_sum_one = r_sum_one + 9'(8'(digit) * 8'(w_one));
            end
            if (r_digit_count < SUM2_TERMS) begin
                n_sum_two = r_sum_two + 10'(8'(digit) * 8'(w_two));
            end
            if (r_digit_count == TENTH_IDX) begin
                n_tenth = digit;
            end
            if (r_digit_count == ELEVEN_IDX) begin
                n_eleventh = digit;
            end
            n_digits      = {r_digits[BCD_W-DIGIT_W-1:0], digit};
            n_digit_count = r_digit_count + 4'd1;
        end

        o_tally.char_count = n_char_count;
        o_tally.plain_ok   = n_plain_ok;
        o_tally.punct_ok   = n_punct_ok;
        o_tally.all_same   = n_all_same;
        o_tally.sum_one    = n_sum_one;
        o_tally.sum_two    = n_sum_two;
        o_tally.tenth      = n_tenth;
        o_tally.eleventh   = n_eleventh;
        o_tally.digits     = n_digits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_char)) begin
            r_char_count  <= '0;
            r_digit_count <= '0;
            r_plain_ok    <= 1'b1;
            r_punct_ok    <= 1'b1;
            r_first       <= '0;
            r_all_same    <= 1'b1;
            r_sum_one     <= '0;
            r_sum_two     <= '0;
            r_tenth       <= '0;
            r_eleventh    <= '0;
            r_digits      <= '0;
        end else if (i_fire) begin
            r_char_count  <= n_char_count;
            r_digit_count <= n_digit_count;
            r_plain_ok    <= n_plain_ok;
            r_punct_ok    <= n_punct_ok;
            r_first       <= n_first;
            r_all_same    <= n_all_same;
            r_sum_one     <= n_sum_one;
            r_sum_two     <= n_sum_two;
            r_tenth       <= n_tenth;
            r_eleventh    <= n_eleventh;
            r_digits      <= n_digits;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.last_char) |=> (r_char_count == 4'd0 && r_digit_count == 4'd0))
        else $error("tally not cleared after final character");

    a_digits_within_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_digit_count <= r_char_count) && (r_digit_count <= NUM_DIGITS))
        else $error("digit count out of step with character count");

endmodule
`default_nettype wire

/* rtl/cpf_verdict.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_verdict
// length, character, all-equal and mod-11 checks on the final tally
// ----------------------------------------------------------------------------
module cpf_verdict (
    input  wire cpf_pkg::t_cpf_tally i_tally,
    output cpf_pkg::t_cpf_out        o_result
);
    import cpf_pkg::*;

    logic [2:0] status;
    logic [3:0] check_one;
    logic [3:0] check_two;

    always_comb begin
        check_one = check_from_sum({1'b0, i_tally.sum_one});
        check_two = check_from_sum(i_tally.sum_two);

        if (i_tally.char_count == PLAIN_LEN) begin
            status = i_tally.plain_ok ? ST_OK : ST_BAD_CHAR;
        end else if (i_tally.char_count == PUNCT_LEN) begin
            status = i_tally.punct_ok ? ST_OK : ST_BAD_CHAR;
        end else begin
            status = ST_BAD_LEN;
        end

        if (status == ST_OK) begin
            if (i_tally.all_same) begin
                status = ST_ALL_EQUAL;
            end else if (i_tally.tenth != check_one) begin
                status = ST_CHECK_ONE;
            end else if (i_tally.eleventh != check_two) begin
                status = ST_CHECK_TWO;
            end
        end

        o_result.is_valid   = (status == ST_OK);
        o_result.status     = status;
        o_result.digits_bcd = ((status == ST_BAD_LEN) || (status == ST_BAD_CHAR)) ?
                              '0 : i_tally.digits;
    end

endmodule
`default_nettype wire

/* rtl/cpf_check_digit_validator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpf_check_digit_validator_unit
// taxpayer number check digit validator: one character per transaction,
// one verdict transaction on the final character
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    i_in_data  (t_cpf_in)
//   out      source     o_out_valid / i_out_ready  o_out_data (t_cpf_out)
//
// one character per cycle unless a final character waits on a held result;
// its verdict is registered via the input register, then the result register
// the tally update and the mod-11 checks sit between those two registers
// synchronous active-low reset empties both registers and clears the tally
// only a final character waits on a held result; others pass straight on
// ----------------------------------------------------------------------------
module cpf_check_digit_validator_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire cpf_pkg::t_cpf_in   i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output cpf_pkg::t_cpf_out       o_out_data
);
    import cpf_pkg::*;

    logic       r_s1_valid;
    t_cpf_in    r_s1;
    logic       r_out_valid;
    t_cpf_out   r_out;

    logic       out_free;
    logic       s1_fire;
    logic       in_fire;
    t_cpf_tally tally;
    t_cpf_out   verdict;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && (!r_s1.last_char || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    cpf_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_s1),
        .o_tally (tally)
    );

    cpf_verdict u_verdict (
        .i_tally  (tally),
        .o_result (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.last_char) begin
            r_out <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_valid_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_valid == (r_out.status == ST_OK)))
        else $error("is_valid disagrees with status");

    a_rejected_digits_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_out.status == ST_BAD_LEN) || (r_out.status == ST_BAD_CHAR)))
        |-> (r_out.digits_bcd == '0))
        else $error("digits shown for a malformed number");

    a_last_waits_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1.last_char && r_out_valid && !i_out_ready) |=> r_s1_valid)
        else $error("final character dropped while result held");

endmodule
`default_nettype wire
